// File: rtl/nhtsl_pkg.sv
// shared types and constants for the latency-sorted next-hop table
package nhtsl_pkg;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// one stored next hop
	typedef struct packed {
		logic [31:0] latency;
		logic [31:0] cost;
		logic        mac_ok;
		logic [47:0] mac;
		logic [7:0]  face;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DONE
	} state_t;

endpackage

// File: rtl/next_hop_table_sorted_by_latency_top.sv
// top level: latency-sorted next-hop table built around one slot memory
// a lookup reads and checks the slots from the front; an add then slides the slot toward
// the front or the back into latency order, and a remove closes up the slots behind it
// takes one item at a time; a new beat is accepted only while idle, and the
// input is ready again once the result register has taken the beat
// reset: asynchronous; clears the entry count and control, slot memory is not cleared
module next_hop_table_sorted_by_latency_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // face_id[7:0], mac_address[55:8], mac_ok[56],
	                               // cost[88:57], latency[120:89], zero fill
	input  logic [1:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata   // hit[0], dropped[1], entry_count[6:2], zero fill
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// slot memory, one read and one write port
	nhtsl_pkg::slot_t mem [TABLE_DEPTH];
	nhtsl_pkg::slot_t rd_q;
	logic [IW-1:0] ra, wa;
	logic we;
	nhtsl_pkg::slot_t wd;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	nhtsl_pkg::state_t st_q, st_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [CW-1:0] idx_q, idx_n;
	logic [1:0] kind_q;
	logic [7:0] face_q;
	logic [47:0] mac_q;
	logic mok_q;
	logic [31:0] cost_q, lat_q;
	logic hit_q, hit_n, drop_q, drop_n;
	nhtsl_pkg::slot_t upd_q, upd_n;
	logic [7:0] res_n;
	logic ld_in;

	assign s_tready = (st_q == nhtsl_pkg::ST_IDLE);
	assign ld_in = s_tvalid && s_tready;

	// match of the slot just read against the held request
	logic match;
	always_comb begin
		case (kind_q)
			nhtsl_pkg::KIND_ADD:
				match = mok_q ? (rd_q.mac_ok && rd_q.mac == mac_q) : (rd_q.face == face_q);
			nhtsl_pkg::KIND_QUERY:
				match = (rd_q.face == face_q) && (!mok_q || (rd_q.mac_ok && rd_q.mac == mac_q));
			default: match = (rd_q.face == face_q);
		endcase
	end

	// sequencer
	always_comb begin
		st_n = st_q;
		cnt_n = cnt_q;
		idx_n = idx_q;
		hit_n = hit_q;
		drop_n = drop_q;
		upd_n = upd_q;
		ra = idx_q[IW-1:0];
		wa = idx_q[IW-1:0];
		we = 1'b0;
		wd = upd_q;
		case (st_q)
			nhtsl_pkg::ST_IDLE: begin
				idx_n = '0;
				hit_n = 1'b0;
				drop_n = 1'b0;
				if (ld_in) st_n = nhtsl_pkg::ST_SCAN_RD;
			end
			nhtsl_pkg::ST_SCAN_RD: begin
				if (kind_q != nhtsl_pkg::KIND_ADD && kind_q != nhtsl_pkg::KIND_REMOVE
				    && kind_q != nhtsl_pkg::KIND_QUERY) begin
					st_n = nhtsl_pkg::ST_DONE;
				end else if (idx_q >= cnt_q) begin
					// miss
					if (kind_q == nhtsl_pkg::KIND_ADD) begin
						if (cnt_q == CW'(TABLE_DEPTH)) begin
							drop_n = 1'b1;
							st_n = nhtsl_pkg::ST_DONE;
						end else begin
							upd_n.face = face_q;
							upd_n.cost = cost_q;
							upd_n.latency = lat_q;
							upd_n.mac = mac_q;
							upd_n.mac_ok = mok_q;
							cnt_n = cnt_q + 1'b1;
							st_n = nhtsl_pkg::ST_SHIFT_RD;
						end
					end else begin
						st_n = nhtsl_pkg::ST_DONE;
					end
				end else begin
					st_n = nhtsl_pkg::ST_SCAN_CHK;
				end
			end
			nhtsl_pkg::ST_SCAN_CHK: begin
				if (match) begin
					hit_n = 1'b1;
					case (kind_q)
						nhtsl_pkg::KIND_ADD: begin
							upd_n = rd_q;
							if (rd_q.cost == '0) upd_n.cost = cost_q;
							upd_n.latency = lat_q;
							upd_n.mac = mac_q;
							upd_n.mac_ok = mok_q;
							st_n = nhtsl_pkg::ST_UPD_RD;
						end
						nhtsl_pkg::KIND_REMOVE: st_n = nhtsl_pkg::ST_DEL_RD;
						default: st_n = nhtsl_pkg::ST_DONE;
					endcase
				end else begin
					idx_n = idx_q + 1'b1;
					st_n = nhtsl_pkg::ST_SCAN_RD;
				end
			end
			// updated slot at idx: slide toward front while predecessor is larger,
			// else toward back while successor is smaller
			nhtsl_pkg::ST_UPD_RD: begin
				if (idx_q != '0) begin
					ra = IW'(idx_q - 1'b1);
					st_n = nhtsl_pkg::ST_UPD_WR;
				end else begin
					ra = IW'(idx_q + 1'b1);
					st_n = nhtsl_pkg::ST_SHIFT_WR;
				end
			end
			nhtsl_pkg::ST_UPD_WR: begin
				if (rd_q.latency > upd_q.latency) begin
					we = 1'b1;
					wd = rd_q;
					idx_n = idx_q - 1'b1;
					st_n = nhtsl_pkg::ST_SHIFT_RD;
				end else begin
					ra = IW'(idx_q + 1'b1);
					st_n = nhtsl_pkg::ST_SHIFT_WR;
				end
			end
			// new slot at end or moving front: compare with predecessor
			nhtsl_pkg::ST_SHIFT_RD: begin
				if (idx_q == '0) begin
					we = 1'b1;
					st_n = nhtsl_pkg::ST_DONE;
				end else begin
					ra = IW'(idx_q - 1'b1);
					st_n = nhtsl_pkg::ST_UPD_WR;
				end
			end
			// moving back: compare with successor
			nhtsl_pkg::ST_SHIFT_WR: begin
				if (idx_q + 1'b1 < cnt_q && rd_q.latency < upd_q.latency) begin
					we = 1'b1;
					wd = rd_q;
					idx_n = idx_q + 1'b1;
					ra = IW'(idx_q + 2'd2);
					st_n = nhtsl_pkg::ST_SHIFT_WR;
				end else begin
					we = 1'b1;
					st_n = nhtsl_pkg::ST_DONE;
				end
			end
			nhtsl_pkg::ST_DEL_RD: begin
				if (idx_q + 1'b1 >= cnt_q) begin
					cnt_n = cnt_q - 1'b1;
					st_n = nhtsl_pkg::ST_DONE;
				end else begin
					ra = IW'(idx_q + 1'b1);
					st_n = nhtsl_pkg::ST_DEL_WR;
				end
			end
			nhtsl_pkg::ST_DEL_WR: begin
				we = 1'b1;
				wd = rd_q;
				idx_n = idx_q + 1'b1;
				st_n = nhtsl_pkg::ST_DEL_RD;
			end
			nhtsl_pkg::ST_DONE: begin
				if (!m_tvalid || m_tready) st_n = nhtsl_pkg::ST_IDLE;
			end
			default: st_n = nhtsl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= nhtsl_pkg::ST_IDLE;
			cnt_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			st_q <= st_n;
			cnt_q <= cnt_n;
			if (st_q == nhtsl_pkg::ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	// result beat packing
	always_comb begin
		res_n = '0;
		res_n[0] = hit_q;
		res_n[1] = drop_q;
		res_n[6:2] = 5'(cnt_q);
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_n;
		hit_q <= hit_n;
		drop_q <= drop_n;
		upd_q <= upd_n;
		if (st_q == nhtsl_pkg::ST_DONE && (!m_tvalid || m_tready)) m_tdata <= res_n;
		if (ld_in) begin
			face_q <= s_tdata[7:0];
			mac_q <= s_tdata[55:8];
			mok_q <= s_tdata[56];
			cost_q <= s_tdata[88:57];
			lat_q <= s_tdata[120:89];
			kind_q <= s_tuser;
		end
	end

endmodule

// File: bench/testbench.sv
// self-checking bench for the latency-sorted next-hop table
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [1:0] KIND_BAD = 2'd3;

	typedef struct packed {
		logic       hit;
		logic       dropped;
		logic [4:0] entry_count;
	} answer_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;

	// software copy of the table
	nhtsl_pkg::slot_t hop_slot [DEPTH];
	int      hop_used;
	answer_t answer_q[$];
	int      fail_count;
	bit      calm;
	int      cycles;

	next_hop_table_sorted_by_latency_top #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// stable insertion sort by latency
	function automatic void resort_hops();
		nhtsl_pkg::slot_t held;
		int    j;
		for (int i = 1; i < hop_used; i++) begin
			held = hop_slot[i];
			j = i;
			while (j > 0 && hop_slot[j - 1].latency > held.latency) begin
				hop_slot[j] = hop_slot[j - 1];
				j--;
			end
			hop_slot[j] = held;
		end
	endfunction

	// predict the answer to one operation and update the table copy
	function automatic answer_t predict_hop(logic [1:0] kind, nhtsl_pkg::slot_t op);
		answer_t a;
		int      idx;
		a = '0;
		idx = -1;
		if (kind == nhtsl_pkg::KIND_ADD) begin
			for (int i = 0; i < hop_used && idx < 0; i++)
				if (op.mac_ok ? (hop_slot[i].mac_ok && hop_slot[i].mac == op.mac)
				              : (hop_slot[i].face == op.face))
					idx = i;
			if (idx >= 0) begin
				a.hit = 1'b1;
			end else if (hop_used < DEPTH) begin
				idx = hop_used;
				hop_slot[idx].face = op.face;
				hop_slot[idx].cost = '0;
				hop_used++;
			end else begin
				a.dropped = 1'b1;
			end
			if (idx >= 0) begin
				if (hop_slot[idx].cost == 0)
					hop_slot[idx].cost = op.cost;
				hop_slot[idx].latency = op.latency;
				hop_slot[idx].mac = op.mac;
				hop_slot[idx].mac_ok = op.mac_ok;
				resort_hops();
			end
		end else if (kind == nhtsl_pkg::KIND_REMOVE) begin
			for (int i = 0; i < hop_used && idx < 0; i++)
				if (hop_slot[i].face == op.face)
					idx = i;
			if (idx >= 0) begin
				a.hit = 1'b1;
				for (int i = idx; i + 1 < hop_used; i++)
					hop_slot[i] = hop_slot[i + 1];
				hop_used--;
			end
		end else if (kind == nhtsl_pkg::KIND_QUERY) begin
			for (int i = 0; i < hop_used; i++)
				if (hop_slot[i].face == op.face &&
				    (!op.mac_ok || (hop_slot[i].mac_ok && hop_slot[i].mac == op.mac)))
					a.hit = 1'b1;
		end
		a.entry_count = 5'(hop_used);
		return a;
	endfunction

	// send one beat, sometimes with a random gap before it; valid stays up until the next gap
	task automatic send_hop(logic [1:0] kind, nhtsl_pkg::slot_t op);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'd0, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		answer_q.insert(answer_q.size(), predict_hop(kind, op));
	endtask

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit = m_tdata[0];
			got.dropped = m_tdata[1];
			got.entry_count = m_tdata[6:2];
			if (m_tdata[7] !== 1'b0) begin
				$error("fill: expected 0 actual %0d", m_tdata[7]);
				fail_count++;
			end
			if (answer_q.size() == 0) begin
				$error("unexpected result beat %h", m_tdata);
				fail_count++;
			end else begin
				want = answer_q.pop_front();
				if (got.hit !== want.hit) begin
					$error("hit: expected %0d actual %0d", want.hit, got.hit);
					fail_count++;
				end
				if (got.dropped !== want.dropped) begin
					$error("dropped: expected %0d actual %0d", want.dropped, got.dropped);
					fail_count++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d actual %0d",
					       want.entry_count, got.entry_count);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int burst;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 13);
				m_tready <= 1'b0;
				repeat (burst) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic nhtsl_pkg::slot_t make_hop(logic [7:0] face, logic [47:0] mac,
	                                              logic ok, logic [31:0] cost,
	                                              logic [31:0] lat);
		nhtsl_pkg::slot_t s;
		s.face = face; s.mac = mac; s.mac_ok = ok; s.cost = cost; s.latency = lat;
		return s;
	endfunction

	function automatic nhtsl_pkg::slot_t random_hop(int face_span, int mac_span);
		nhtsl_pkg::slot_t s;
		s.face = (face_span == 0) ? 8'($urandom) : 8'($urandom_range(0, face_span));
		s.mac = (mac_span == 0) ? {16'($urandom), 32'($urandom)}
		                        : 48'($urandom_range(0, mac_span));
		s.mac_ok = 1'($urandom);
		s.cost = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
		s.latency = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
		return s;
	endfunction

	// drop valid and wait for every outstanding result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
	endtask

	// field extremes, every kind, full table, misses, unknown kind
	task automatic test_directed();
		send_hop(nhtsl_pkg::KIND_QUERY, make_hop(8'd0, 48'd0, 1'b0, 32'd0, 32'd0));
		send_hop(nhtsl_pkg::KIND_REMOVE, make_hop(8'd5, 48'd0, 1'b0, 32'd0, 32'd0));
		send_hop(nhtsl_pkg::KIND_ADD, make_hop(8'hff, 48'hffff_ffff_ffff, 1'b1,
		                                       32'hffff_ffff, 32'hffff_ffff));
		send_hop(nhtsl_pkg::KIND_ADD, make_hop(8'd0, 48'd0, 1'b0, 32'd0, 32'd0));
		send_hop(nhtsl_pkg::KIND_ADD, make_hop(8'd0, 48'h1234, 1'b0, 32'd9, 32'd3));
		send_hop(nhtsl_pkg::KIND_ADD, make_hop(8'd7, 48'hffff_ffff_ffff, 1'b1, 32'd1,
		                                       32'd0));
		send_hop(nhtsl_pkg::KIND_QUERY, make_hop(8'hff, 48'hffff_ffff_ffff, 1'b1, 32'd0,
		                                         32'd0));
		send_hop(nhtsl_pkg::KIND_QUERY, make_hop(8'd7, 48'hffff_ffff_ffff, 1'b1, 32'd0,
		                                         32'd0));
		send_hop(nhtsl_pkg::KIND_QUERY, make_hop(8'd0, 48'h1234, 1'b1, 32'd0, 32'd0));
		send_hop(KIND_BAD, make_hop(8'd0, 48'd0, 1'b0, 32'd0, 32'd0));
		send_hop(KIND_BAD, make_hop(8'hff, 48'hffff_ffff_ffff, 1'b1, 32'hffff_ffff,
		                            32'hffff_ffff));
		for (int i = 0; i < 15; i++)
			send_hop(nhtsl_pkg::KIND_ADD, make_hop(8'(16 + i), 48'(i), 1'b0, 32'(i), 32'd5));
		send_hop(nhtsl_pkg::KIND_ADD, make_hop(8'd99, 48'h77, 1'b1, 32'd4, 32'd1));
		send_hop(nhtsl_pkg::KIND_REMOVE, make_hop(8'd7, 48'd0, 1'b0, 32'd0, 32'd0));
		send_hop(nhtsl_pkg::KIND_REMOVE, make_hop(8'd7, 48'd0, 1'b0, 32'd0, 32'd0));
		wait_drained();
	endtask

	// random mix with small id spaces so entries collide and the table fills
	task automatic test_random(int count);
		logic [1:0] kind;
		int         pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 19);
			kind = (pick < 10) ? nhtsl_pkg::KIND_ADD : (pick < 15) ? nhtsl_pkg::KIND_REMOVE :
			       (pick < 19) ? nhtsl_pkg::KIND_QUERY : KIND_BAD;
			if ($urandom_range(0, 9) == 0)
				send_hop(kind, random_hop(0, 0));
			else
				send_hop(kind, random_hop(23, 15));
		end
	endtask

	// sender holds off until every result is back
	task automatic test_hold_off();
		test_random(40);
		wait_drained();
		test_random(40);
	endtask

	initial begin
		fail_count = 0;
		calm = 1'b0;
		hop_used = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1400);
		test_hold_off();
		calm = 1'b1;
		test_random(200);
		wait_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && answer_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
